// File: design/lcr_pkg.sv
// shared types and constants for the longest consecutive run block
package lcr_pkg;

    localparam int DEFAULT_MAX_VALUES = 256;
    localparam int KEY_W              = 32;
    localparam int RUN_W              = 9;
    localparam logic [RUN_W-1:0] RUN_MAX   = '1;
    localparam logic [KEY_W-1:0] SIGN_BIAS = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_TOP   = '1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SH_CHK,
        ST_SH_WR,
        ST_F_START,
        ST_F_INIT,
        ST_F_RD,
        ST_F_STEP,
        ST_F_OUT
    } state_t;

    typedef struct packed {
        logic load_key;
        logic idx_clr;
        logic idx_inc;
        logic idx_from_cnt;
        logic pos_load;
        logic rd_en;
        logic rd_prev;
        logic wr_shift;
        logic wr_key;
        logic set_drop;
        logic run_zero;
        logic run_init;
        logic run_step;
        logic clear;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic             cnt_zero;
        logic             full;
        logic             idx_at_cnt;
        logic             idx_at_pos;
        logic             eq;
        logic             gt;
        logic [RUN_W-1:0] run_length;
        logic             dropped;
    } stat_t;

endpackage

// File: design/lcr_ctrl.sv
// controller state machine: sorted insert, drop on full, run scan on finish
module lcr_ctrl
    import lcr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  logic  s_op,
    input  logic  out_free,
    input  stat_t stat,
    output logic  s_tready,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_op == OP_FINISH) ? ST_F_START : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (stat.idx_at_cnt) begin
                    state_next = stat.full ? ST_IDLE : ST_SH_CHK;
                end else begin
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (stat.eq) begin
                    state_next = ST_IDLE;
                end else if (stat.gt) begin
                    state_next = stat.full ? ST_IDLE : ST_SH_CHK;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SH_CHK:  state_next = stat.idx_at_pos ? ST_IDLE : ST_SH_WR;
            ST_SH_WR:   state_next = ST_SH_CHK;
            ST_F_START: state_next = stat.cnt_zero ? ST_F_OUT : ST_F_INIT;
            ST_F_INIT:  state_next = ST_F_RD;
            ST_F_RD:    state_next = stat.idx_at_cnt ? ST_F_OUT : ST_F_STEP;
            ST_F_STEP:  state_next = ST_F_RD;
            ST_F_OUT:   state_next = out_free ? ST_IDLE : ST_F_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    cmd.idx_clr = 1'b1;
                    if (s_op == OP_FINISH) begin
                        cmd.run_zero = 1'b1;
                    end else begin
                        cmd.load_key = 1'b1;
                    end
                end
            end
            ST_SCAN_RD: begin
                if (stat.idx_at_cnt) begin
                    if (stat.full) begin
                        cmd.set_drop = 1'b1;
                    end else begin
                        cmd.pos_load     = 1'b1;
                        cmd.idx_from_cnt = 1'b1;
                    end
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            ST_SCAN_CMP: begin
                if (!stat.eq) begin
                    if (stat.gt) begin
                        if (stat.full) begin
                            cmd.set_drop = 1'b1;
                        end else begin
                            cmd.pos_load     = 1'b1;
                            cmd.idx_from_cnt = 1'b1;
                        end
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_SH_CHK: begin
                if (stat.idx_at_pos) begin
                    cmd.wr_key = 1'b1;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_prev = 1'b1;
                end
            end
            ST_SH_WR: cmd.wr_shift = 1'b1;
            ST_F_START: begin
                if (!stat.cnt_zero) begin
                    cmd.rd_en   = 1'b1;
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_F_INIT: cmd.run_init = 1'b1;
            ST_F_RD: begin
                if (!stat.idx_at_cnt) begin
                    cmd.rd_en   = 1'b1;
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_F_STEP: cmd.run_step = 1'b1;
            ST_F_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

// File: design/lcr_datapath.sv
// datapath: sorted value memory, count, drop flag and run counters
module lcr_datapath
    import lcr_pkg::*;
#(
    parameter int MAX_VALUES = DEFAULT_MAX_VALUES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [KEY_W-1:0] in_value,
    input  cmd_t             cmd,
    output stat_t            stat
);

    localparam int ADDR_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CNT_W  = $clog2(MAX_VALUES + 1);

    // entries are kept in ascending key order
    logic [KEY_W-1:0] mem [MAX_VALUES];

    logic [KEY_W-1:0] key_reg, rdata_reg, prev_reg;
    logic [CNT_W-1:0] count_reg, idx_reg, pos_reg;
    logic [CNT_W-1:0] idx_m1;
    logic             dropped_reg;
    logic [RUN_W-1:0] cur_reg, best_reg;
    logic [RUN_W-1:0] cur_next;
    logic             consec;
    logic [ADDR_W-1:0] raddr, waddr;

    assign idx_m1 = idx_reg - CNT_W'(1);
    assign raddr  = cmd.rd_prev ? idx_m1[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign waddr  = cmd.wr_key ? pos_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= mem[raddr];
        end
        if (cmd.wr_key) begin
            mem[waddr] <= key_reg;
        end else if (cmd.wr_shift) begin
            mem[waddr] <= rdata_reg;
        end
    end

    // a run never steps past the top key
    assign consec   = (prev_reg != KEY_TOP) && (rdata_reg == prev_reg + KEY_W'(1));
    assign cur_next = consec ? ((cur_reg == RUN_MAX) ? cur_reg : cur_reg + RUN_W'(1))
                             : RUN_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end else begin
                if (cmd.wr_key) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (cmd.set_drop) begin
                    dropped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_reg <= in_value ^ SIGN_BIAS;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_from_cnt) begin
            idx_reg <= count_reg;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end else if (cmd.wr_shift) begin
            idx_reg <= idx_m1;
        end
        if (cmd.pos_load) begin
            pos_reg <= idx_reg;
        end
        if (cmd.run_zero) begin
            best_reg <= '0;
        end else if (cmd.run_init) begin
            prev_reg <= rdata_reg;
            cur_reg  <= RUN_W'(1);
            best_reg <= RUN_W'(1);
        end else if (cmd.run_step) begin
            prev_reg <= rdata_reg;
            cur_reg  <= cur_next;
            if (cur_next > best_reg) begin
                best_reg <= cur_next;
            end
        end
    end

    always_comb begin
        stat.cnt_zero   = (count_reg == '0);
        stat.full       = (count_reg == CNT_W'(MAX_VALUES));
        stat.idx_at_cnt = (idx_reg == count_reg);
        stat.idx_at_pos = (idx_reg == pos_reg);
        stat.eq         = (rdata_reg == key_reg);
        stat.gt         = (rdata_reg > key_reg);
        stat.run_length = best_reg;
        stat.dropped    = dropped_reg;
    end

endmodule

// File: design/longest_consecutive_run.sv
// Longest consecutive run of distinct signed 32-bit values. Insert transfers
// (tuser 0) are checked against a memory held in ascending order: a scan reads
// one entry at a time until it finds the value (duplicate, dropped silently),
// a larger entry or the end; a new value then shifts the larger entries up
// one place, one entry at a time, and is written in. When the store holds
// MAX_VALUES entries a new value is dropped and the overflow flag is set. A
// finish transfer (tuser 1) reads the sorted memory once, entry by entry, and
// reports the longest run (0 when empty, no wrap from the top value to the
// bottom one) with the flag, then clears the store. The result waits in an
// output register while the next items are taken. No clearing pass is needed
// after reset.
module longest_consecutive_run
    import lcr_pkg::*;
#(
    parameter int MAX_VALUES = DEFAULT_MAX_VALUES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [8:0] run_length, [9] overflowed
);

    cmd_t  cmd;
    stat_t stat;

    logic             out_valid_reg;
    logic [RUN_W-1:0] out_run_reg;
    logic             out_ovf_reg;
    logic             out_free;

    assign out_free = !out_valid_reg || m_tready;

    lcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser[0]),
        .out_free (out_free),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    lcr_datapath #(
        .MAX_VALUES (MAX_VALUES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_value (s_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_run_reg <= stat.run_length;
            out_ovf_reg <= stat.dropped;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_ovf_reg, out_run_reg};

`ifndef SYNTHESIS
    // every accepted transfer leaves the block busy, not ready for more input
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.out_load && m_tvalid && !m_tready))
        else $error("result register overwritten");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");

    // store write and drop never happen together
    a_write_or_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_key && cmd.set_drop))
        else $error("value both stored and dropped");
`endif

endmodule

// File: verif/longest_consecutive_run_tb.sv
// self-checking stream testbench for the longest consecutive run block
module longest_consecutive_run_tb
    import lcr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STORE_DEPTH   = DEFAULT_MAX_VALUES;
    localparam int          ITEM_TARGET   = 1250;
    localparam int          DIRECTED_ROWS = 19;
    localparam int          LONG_HOLD     = 400;
    localparam int          DRAIN_CYCLES  = 64;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;

    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic             overflowed;
    } run_report_t;

    typedef struct packed {
        logic        op;
        logic [31:0] value;
        logic        typed;
        run_report_t report;
    } step_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // sorted copy of the distinct keys (sign bit flipped) held since the last finish
    bit [KEY_W-1:0] held_keys[$];
    bit             drop_seen;
    run_report_t    pending_reports[$];

    step_row_t   directed_steps [DIRECTED_ROWS];
    int unsigned mismatch_count  = 0;
    int unsigned items_sent      = 0;
    int unsigned reports_seen    = 0;
    int unsigned frames_sent     = 0;
    int unsigned overflow_frames = 0;
    int unsigned longest_seen    = 0;
    int unsigned cycle_count     = 0;
    bit          long_hold_req   = 1'b0;
    bit          rx_steady       = 1'b0;

    longest_consecutive_run #(
        .MAX_VALUES(STORE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycle_count, pending_reports.size());
                $display("longest_consecutive_run: mismatch");
                $finish;
            end
        end
    end

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void absorb_value(logic [31:0] value);
        bit [KEY_W-1:0] key;
        bit [KEY_W-1:0] tmp;
        int             i;
        key = value ^ SIGN_BIAS;
        foreach (held_keys[k]) begin
            if (held_keys[k] == key) return;
        end
        if (held_keys.size() >= STORE_DEPTH) begin
            drop_seen = 1'b1;
            return;
        end
        held_keys.push_back(key);
        i = held_keys.size() - 1;
        while (i > 0 && held_keys[i-1] > held_keys[i]) begin
            tmp            = held_keys[i];
            held_keys[i]   = held_keys[i-1];
            held_keys[i-1] = tmp;
            i--;
        end
    endfunction

    function automatic run_report_t close_frame();
        run_report_t r;
        int unsigned best;
        int unsigned cur;
        best = (held_keys.size() > 0) ? 1 : 0;
        cur  = 1;
        for (int i = 1; i < held_keys.size(); i++) begin
            // no wrap from the top key to the bottom one
            if (held_keys[i-1] != KEY_TOP && held_keys[i] == held_keys[i-1] + 32'd1)
                cur++;
            else
                cur = 1;
            if (cur > best) best = cur;
        end
        if (best > RUN_MAX) best = RUN_MAX;
        r.run_length = best[RUN_W-1:0];
        r.overflowed = drop_seen;
        held_keys.delete();
        drop_seen = 1'b0;
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic take_report(logic [15:0] data);
        run_report_t want;
        if (pending_reports.size() == 0) begin
            flag_mismatch($sformatf("result %h with nothing expected", data));
            return;
        end
        want = pending_reports.pop_front();
        if (data[RUN_W-1:0] !== want.run_length)
            flag_mismatch($sformatf("result %0d run_length %0d, expected %0d",
                                    reports_seen, data[RUN_W-1:0], want.run_length));
        if (data[RUN_W] !== want.overflowed)
            flag_mismatch($sformatf("result %0d overflowed %b, expected %b",
                                    reports_seen, data[RUN_W], want.overflowed));
        reports_seen++;
    endtask

    // offer one item and hold it until the transfer, then update the prediction
    task automatic offer(logic op, logic [31:0] value, logic typed, run_report_t typed_report);
        run_report_t predicted;
        s_tvalid   <= 1'b1;
        s_tdata    <= value;
        s_tuser[0] <= op;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (op == OP_INSERT) begin
            absorb_value(value);
        end else begin
            predicted = close_frame();
            frames_sent++;
            if (predicted.overflowed) overflow_frames++;
            if (32'(predicted.run_length) > longest_seen)
                longest_seen = 32'(predicted.run_length);
            pending_reports.push_back(typed ? typed_report : predicted);
        end
    endtask

    task automatic sender_idle(int unsigned cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic sender_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stalls, steady stretches, and one long hold on request
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned g;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) take_report(m_tdata);
            if (cycle_count % 200 == 0) rx_steady = ($urandom_range(0, 3) == 0);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                m_tready     <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                g = rx_steady ? 0 : pick_idle();
                if (g > 0) begin
                    stall_left = g - 1;
                    m_tready  <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        run_report_t   rep;
        int unsigned   frame_idx;
        int unsigned   frame_len;
        int unsigned   span;
        int unsigned   r;
        int unsigned   big_left;
        bit            tx_steady;
        logic [31:0]   base;
        logic [31:0]   v;

        // one run across zero, extremes that must not join, duplicates
        directed_steps = '{
            '{OP_FINISH, 32'hFFFF_FFFF, 1'b1, '{9'd0, 1'b0}},
            '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
            '{OP_INSERT, 32'h8000_0000, 1'b0, '0},
            '{OP_FINISH, 32'h0000_0000, 1'b1, '{9'd1, 1'b0}},
            '{OP_INSERT, 32'd5,         1'b0, '0},
            '{OP_INSERT, 32'd5,         1'b0, '0},
            '{OP_INSERT, 32'd6,         1'b0, '0},
            '{OP_INSERT, 32'd4,         1'b0, '0},
            '{OP_FINISH, 32'hA5A5_A5A5, 1'b1, '{9'd3, 1'b0}},
            '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_INSERT, 32'h0000_0000, 1'b0, '0},
            '{OP_INSERT, 32'h0000_0001, 1'b0, '0},
            '{OP_INSERT, 32'h0000_0003, 1'b0, '0},
            '{OP_FINISH, 32'h5A5A_5A5A, 1'b0, '0},
            '{OP_INSERT, 32'h8000_0000, 1'b0, '0},
            '{OP_INSERT, 32'h8000_0001, 1'b0, '0},
            '{OP_INSERT, 32'h7FFF_FFFE, 1'b0, '0},
            '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
            '{OP_FINISH, 32'hFFFF_FFFF, 1'b1, '{9'd2, 1'b0}}
        };
        drop_seen = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            offer(directed_steps[i].op, directed_steps[i].value,
                  directed_steps[i].typed, directed_steps[i].report);
            sender_idle(pick_idle());
        end

        // fill the store in descending order, then a duplicate and a dropped value
        for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
            offer(OP_INSERT, i, 1'b0, '0);
            sender_idle(pick_idle());
        end
        offer(OP_INSERT, 32'd10, 1'b0, '0);
        offer(OP_INSERT, -32'sd5, 1'b0, '0);
        rep.run_length = RUN_W'(STORE_DEPTH);
        rep.overflowed = 1'b1;
        offer(OP_FINISH, 32'h0, 1'b1, rep);
        rep = '0;
        offer(OP_FINISH, 32'h1234_5678, 1'b1, rep);
        sender_drain();

        frame_idx = 0;
        big_left  = 1;
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 5)       frame_len = 0;
            else if (r < 80) frame_len = $urandom_range(1, 10);
            else if (r < 97) frame_len = $urandom_range(11, 40);
            else if (big_left > 0) begin
                frame_len = STORE_DEPTH + $urandom_range(8, 24);
                big_left--;
            end else         frame_len = $urandom_range(1, 6);
            tx_steady = ($urandom_range(0, 4) == 0);

            // short frames back to back while the receiver holds off
            if (frame_idx == 5) long_hold_req = 1'b1;
            if (frame_idx >= 5 && frame_idx < 13) begin
                frame_len = $urandom_range(1, 3);
                tx_steady = 1'b1;
            end

            case ($urandom_range(0, 3))
                0: base = $urandom;
                1: base = 32'h7FFF_FFFF - $urandom_range(0, 24);
                2: base = 32'h8000_0000 + $urandom_range(0, 8);
                default: base = -$urandom_range(0, 12);
            endcase
            span = $urandom_range(frame_len, 2 * frame_len + 2);

            for (int i = 0; i < frame_len; i++) begin
                if (frame_len > STORE_DEPTH)
                    v = base + (i ^ $urandom_range(0, 3));
                else if ($urandom_range(0, 9) == 0)
                    v = $urandom;
                else
                    v = base + $urandom_range(0, span);
                offer(OP_INSERT, v, 1'b0, '0);
                sender_idle(tx_steady ? 0 : pick_idle());
            end
            offer(OP_FINISH, $urandom, 1'b0, '0);
            frame_idx++;

            if (frame_idx % 20 == 0) sender_drain();
            else                     sender_idle(tx_steady ? 0 : pick_idle());
        end

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items in %0d frames, %0d of them overflowing the store",
                 items_sent, frames_sent, overflow_frames);
        $display("checked %0d results, longest run %0d, %0d errors",
                 reports_seen, longest_seen, mismatch_count);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("longest_consecutive_run: match");
        end else begin
            $display("longest_consecutive_run: mismatch");
        end
        $finish;
    end

endmodule
